// ===== sv/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, constants and the byte-wise CRC-16 update for the RTU request framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int CRC_SPAN  = 6;

    typedef logic [2:0] idx_t;

    localparam idx_t LAST_IDX = idx_t'(FRAME_LEN - 1);

    // Frame byte positions
    localparam idx_t IDX_SLAVE    = 3'd0;
    localparam idx_t IDX_FUNC     = 3'd1;
    localparam idx_t IDX_START_HI = 3'd2;
    localparam idx_t IDX_START_LO = 3'd3;
    localparam idx_t IDX_DATA_HI  = 3'd4;
    localparam idx_t IDX_DATA_LO  = 3'd5;
    localparam idx_t IDX_CRC_LO   = 3'd6;
    localparam idx_t IDX_CRC_HI   = 3'd7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_COILS   = 8'd1;
    localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FUNC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'd6;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  func;
        logic [15:0] start_address;
        logic [15:0] data_word;
    } req_t;

    // One byte through the reflected CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mrf_serializer.sv =====
// ----------------------------------------------------------------------------
// mrf_serializer
// Emits one frame byte per cycle from a held request, running the CRC as the
// header bytes go out; it pauses while a stall holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_serializer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire mrf_pkg::req_t req,
    output logic               ready,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         frame_byte,
    output logic               last_byte
);

    mrf_pkg::req_t req_reg;
    logic          busy_reg, busy_next;
    mrf_pkg::idx_t cnt_reg, cnt_next;
    logic [15:0]   crc_reg, crc_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    frame_byte_reg;
    logic          last_byte_reg;

    logic          out_free;
    logic          emit;
    logic          is_last;
    logic [7:0]    cur_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && out_free;
    assign is_last  = (cnt_reg == mrf_pkg::LAST_IDX);
    assign ready    = !busy_reg || (emit && is_last);

    always_comb
    begin
        case (cnt_reg)
            mrf_pkg::IDX_SLAVE:    cur_byte = req_reg.slave_address;
            mrf_pkg::IDX_FUNC:     cur_byte = req_reg.func;
            mrf_pkg::IDX_START_HI: cur_byte = req_reg.start_address[15:8];
            mrf_pkg::IDX_START_LO: cur_byte = req_reg.start_address[7:0];
            mrf_pkg::IDX_DATA_HI:  cur_byte = req_reg.data_word[15:8];
            mrf_pkg::IDX_DATA_LO:  cur_byte = req_reg.data_word[7:0];
            mrf_pkg::IDX_CRC_LO:   cur_byte = crc_reg[7:0];
            mrf_pkg::IDX_CRC_HI:   cur_byte = crc_reg[15:8];
            default:               cur_byte = req_reg.slave_address;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            crc_next  = mrf_pkg::CRC_INIT;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (is_last)
                busy_next = 1'b0;
            // CRC covers the six header bytes only
            if (cnt_reg < mrf_pkg::idx_t'(mrf_pkg::CRC_SPAN))
                crc_next = mrf_pkg::crc_byte(crc_reg, cur_byte);
        end
    end

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (load)
            req_reg <= req;
        if (emit)
        begin
            frame_byte_reg <= cur_byte;
            last_byte_reg  <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last_byte  = last_byte_reg;

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_request_framer.sv =====
// First frame byte passes the input, serializer and output registers.
// Request rate is set by the one-byte output channel; a new request is taken
// into the input register while a frame is going out.
// Unsupported function codes are taken and dropped, producing no bytes.
// Reset (rst_n low, async) empties the input register, serializer and output.
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// Turns a request item into an 8-byte RTU request frame with CRC-16.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  slave_address,
    input  wire logic [7:0]  func,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] data_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic             last_byte
);

    mrf_pkg::req_t hold_reg;
    logic          hold_valid_reg, hold_valid_next;
    logic          in_xfer;
    logic          supported;
    logic          ser_ready;
    logic          ser_load;

    assign in_stall  = hold_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign supported = func inside {mrf_pkg::FUNC_READ_COILS, mrf_pkg::FUNC_READ_HOLDING,
                                    mrf_pkg::FUNC_READ_INPUT, mrf_pkg::FUNC_WRITE_SINGLE};
    assign ser_load  = hold_valid_reg && ser_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_xfer && supported)
            hold_valid_next = 1'b1;
        else if (ser_load)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hold_reg.slave_address <= slave_address;
            hold_reg.func          <= func;
            hold_reg.start_address <= start_address;
            hold_reg.data_word     <= data_word;
        end
    end

    mrf_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ser_load),
        .req        (hold_reg),
        .ready      (ser_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

`default_nettype wire

// ===== sv/mrf_checker.sv =====
// ----------------------------------------------------------------------------
// mrf_checker
// Port-level checks on the request framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [7:0]  func,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  frame_byte,
    input wire logic        last_byte
);

    // Stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_byte) && $stable(last_byte))
        else $error("stalled output payload changed");

    // Bytes of one frame go out back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_byte |=> out_valid)
        else $error("gap inside a frame");

    // A supported request is held, so the input stalls right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (func == mrf_pkg::FUNC_READ_COILS || func == mrf_pkg::FUNC_READ_HOLDING ||
         func == mrf_pkg::FUNC_READ_INPUT || func == mrf_pkg::FUNC_WRITE_SINGLE)
        |=> in_stall)
        else $error("supported request was not held");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
);

`default_nettype wire
